// ===== sv/mesh_ttl_guard_lru_dedup_top_macros.svh =====
// Assertion macros for the mesh TTL guard checker.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef MESH_TTL_GUARD_LRU_DEDUP_TOP_MACROS_SVH
`define MESH_TTL_GUARD_LRU_DEDUP_TOP_MACROS_SVH

// same-cycle implication
`define MTGLD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTGLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mtgld_pkg.sv =====
// Shared types and constants for the mesh TTL guard with LRU seen set.
// No dependencies.
package mtgld_pkg;

    localparam int ID_W           = 16;
    localparam int TTL_W          = 8;
    localparam int NODE_W         = 32;
    localparam int CAP_W          = 5;
    localparam int STAMP_W        = 32;
    localparam int VERDICT_W      = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int SEEN_SLOTS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEN_CAP    = 2'd2;

    localparam logic [NODE_W-1:0] OWN_NODE_RST    = '0;
    localparam logic [TTL_W-1:0]  TTL_CEILING_RST = 8'd7;
    localparam logic [CAP_W-1:0]  SEEN_CAP_RST    = 5'd16;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT    = 3'd0,
        V_DROP_TTL  = 3'd1,
        V_DROP_OWN  = 3'd2,
        V_REFRESH   = 3'd3,
        V_DROP_SEEN = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [NODE_W-1:0] own_node_id;
        logic [TTL_W-1:0]  ttl_ceiling;
        logic [CAP_W-1:0]  seen_capacity;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic             touch;
        verdict_t         verdict;
        logic [TTL_W-1:0] new_ttl;
    } job_t;

endpackage

// ===== sv/mtgld_ifs.sv =====
// Channel interfaces: received records, verdicts and configuration writes.
// Depends on mtgld_pkg.
interface mtgld_rec_if;
    logic                            valid;
    logic                            ready;
    logic [mtgld_pkg::ID_W-1:0]      record_id;
    logic [mtgld_pkg::TTL_W-1:0]     wire_ttl;
    logic [mtgld_pkg::NODE_W-1:0]    origin_id;
    logic                            in_pool;
    logic [mtgld_pkg::TTL_W-1:0]     pool_hops;

    modport source (output valid, record_id, wire_ttl, origin_id, in_pool, pool_hops,
                    input ready);
    modport sink   (input valid, record_id, wire_ttl, origin_id, in_pool, pool_hops,
                    output ready);
endinterface

interface mtgld_res_if;
    logic                            valid;
    logic                            ready;
    logic [mtgld_pkg::VERDICT_W-1:0] verdict;
    logic [mtgld_pkg::TTL_W-1:0]     new_ttl;

    modport source (output valid, verdict, new_ttl, input ready);
    modport sink   (input valid, verdict, new_ttl, output ready);
endinterface

interface mtgld_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mtgld_pkg::CFG_IDX_W-1:0]  index;
    logic [mtgld_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/mtgld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtgld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/mtgld_front.sv =====
// Front end: configuration registers, TTL clamp and verdict classification.
// Depends on mtgld_pkg and mtgld_ifs.
module mtgld_front (
    input  logic              clk,
    input  logic              rst_n,
    mtgld_rec_if.sink         rec,
    mtgld_cfg_if.sink         cfg,
    output mtgld_pkg::cfg_t   cfg_out,
    output logic              job_valid,
    output mtgld_pkg::job_t   job,
    input  logic              job_ready
);

    mtgld_pkg::cfg_t cfg_reg;
    mtgld_pkg::cfg_t cfg_next;
    logic            job_valid_reg;
    logic            job_valid_next;
    mtgld_pkg::job_t job_reg;
    mtgld_pkg::job_t job_next;

    logic [mtgld_pkg::TTL_W-1:0] ttl_clamped;
    logic                        own_hit;
    logic                        rec_take;

    assign cfg.ready = 1'b1;
    assign rec.ready = !job_valid_reg || job_ready;
    assign rec_take  = rec.valid && rec.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mtgld_pkg::CFG_OWN_NODE:
                    cfg_next.own_node_id = cfg.data;
                mtgld_pkg::CFG_TTL_CEILING:
                    cfg_next.ttl_ceiling = cfg.data[mtgld_pkg::TTL_W-1:0];
                mtgld_pkg::CFG_SEEN_CAP:
                    cfg_next.seen_capacity = cfg.data[mtgld_pkg::CAP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        ttl_clamped = (rec.wire_ttl > cfg_reg.ttl_ceiling) ? cfg_reg.ttl_ceiling : rec.wire_ttl;
        own_hit     = (rec.origin_id != '0) && (rec.origin_id == cfg_reg.own_node_id);

        job_next    = job_reg;
        if (rec_take)
        begin
            job_next.id = rec.record_id;
            if (ttl_clamped == '0)
            begin
                job_next.touch   = 1'b0;
                job_next.verdict = mtgld_pkg::V_DROP_TTL;
                job_next.new_ttl = '0;
            end
            else if (own_hit)
            begin
                job_next.touch   = 1'b0;
                job_next.verdict = mtgld_pkg::V_DROP_OWN;
                job_next.new_ttl = '0;
            end
            else if (rec.in_pool)
            begin
                job_next.touch   = 1'b1;
                job_next.verdict = mtgld_pkg::V_REFRESH;
                job_next.new_ttl = (ttl_clamped < rec.pool_hops) ? ttl_clamped : rec.pool_hops;
            end
            else
            begin
                job_next.touch   = 1'b1;
                job_next.verdict = mtgld_pkg::V_ACCEPT;
                job_next.new_ttl = ttl_clamped - 1'b1;
            end
        end

        job_valid_next = rec_take || (job_valid_reg && !job_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_node_id   <= mtgld_pkg::OWN_NODE_RST;
            cfg_reg.ttl_ceiling   <= mtgld_pkg::TTL_CEILING_RST;
            cfg_reg.seen_capacity <= mtgld_pkg::SEEN_CAP_RST;
            job_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign cfg_out   = cfg_reg;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

// ===== sv/mtgld_queue.sv =====
// Short FIFO of classified jobs between the front and back ends.
// Depends on mtgld_pkg.
module mtgld_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  mtgld_pkg::job_t in_job,
    output logic            in_ready,
    output logic            out_valid,
    output mtgld_pkg::job_t out_job,
    input  logic            out_ready
);

    localparam int QPW = (mtgld_pkg::QUEUE_DEPTH > 1) ? $clog2(mtgld_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(mtgld_pkg::QUEUE_DEPTH + 1);

    mtgld_pkg::job_t  entry_reg [mtgld_pkg::QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QPW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != QCW'(mtgld_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(mtgld_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(mtgld_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

// ===== sv/mtgld_back.sv =====
// Back end: LRU seen-set engine over a slot RAM, and the result register.
// Depends on mtgld_pkg, mtgld_ifs and mtgld_ram.
module mtgld_back #(
    parameter int SEEN_SLOTS = mtgld_pkg::SEEN_SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mtgld_pkg::cfg_t cfg,
    input  logic            job_valid,
    input  mtgld_pkg::job_t job,
    output logic            job_ready,
    mtgld_res_if.source     res
);

    localparam int IW    = (SEEN_SLOTS > 1) ? $clog2(SEEN_SLOTS) : 1;
    localparam int CW    = $clog2(SEEN_SLOTS + 1);
    localparam int CAPW  = (CW > mtgld_pkg::CAP_W) ? CW : mtgld_pkg::CAP_W;
    localparam int SLOTW = mtgld_pkg::ID_W + mtgld_pkg::STAMP_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    mtgld_pkg::job_t               job_reg;
    mtgld_pkg::job_t               job_next;
    logic [mtgld_pkg::STAMP_W-1:0] use_clock_reg;
    logic [mtgld_pkg::STAMP_W-1:0] use_clock_next;
    logic [CW-1:0]                 slots_used_reg;
    logic [CW-1:0]                 slots_used_next;
    logic [IW-1:0]                 scan_idx_reg;
    logic [IW-1:0]                 scan_idx_next;
    logic                          hit_reg;
    logic                          hit_next;
    logic [IW-1:0]                 hit_idx_reg;
    logic [IW-1:0]                 hit_idx_next;
    logic [mtgld_pkg::STAMP_W-1:0] min_stamp_reg;
    logic [mtgld_pkg::STAMP_W-1:0] min_stamp_next;
    logic [IW-1:0]                 victim_reg;
    logic [IW-1:0]                 victim_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    mtgld_pkg::verdict_t           out_verdict_reg;
    mtgld_pkg::verdict_t           out_verdict_next;
    logic [mtgld_pkg::TTL_W-1:0]   out_ttl_reg;
    logic [mtgld_pkg::TTL_W-1:0]   out_ttl_next;

    logic                          ram_wr_en;
    logic [IW-1:0]                 ram_wr_addr;
    logic [SLOTW-1:0]              ram_wr_data;
    logic                          ram_rd_en;
    logic [IW-1:0]                 ram_rd_addr;
    logic [SLOTW-1:0]              ram_rd_data;

    logic [mtgld_pkg::ID_W-1:0]    cur_id;
    logic [mtgld_pkg::STAMP_W-1:0] cur_stamp;
    logic [CAPW-1:0]               cap_eff;
    logic                          can_insert;
    logic                          scan_last;
    logic                          scan_match;

    assign cur_stamp  = ram_rd_data[mtgld_pkg::STAMP_W-1:0];
    assign cur_id     = ram_rd_data[SLOTW-1:mtgld_pkg::STAMP_W];
    assign cap_eff    = (CAPW'(cfg.seen_capacity) > CAPW'(SEEN_SLOTS)) ? CAPW'(SEEN_SLOTS)
                                                                       : CAPW'(cfg.seen_capacity);
    assign can_insert = (CAPW'(slots_used_reg) < cap_eff);
    assign scan_last  = ((CW'(scan_idx_reg) + CW'(1)) == slots_used_reg);
    assign scan_match = (cur_id == job_reg.id);
    assign job_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        job_next         = job_reg;
        use_clock_next   = use_clock_reg;
        slots_used_next  = slots_used_reg;
        scan_idx_next    = scan_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        min_stamp_next   = min_stamp_reg;
        victim_next      = victim_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        out_verdict_next = out_verdict_reg;
        out_ttl_next     = out_ttl_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = victim_reg;
        ram_wr_data      = {job_reg.id, use_clock_reg};
        ram_rd_en        = 1'b0;
        ram_rd_addr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next      = job;
                    hit_next      = 1'b0;
                    scan_idx_next = '0;
                    if (job.touch && (cfg.seen_capacity != '0))
                    begin
                        use_clock_next = use_clock_reg + 1'b1;
                        if (slots_used_reg == '0)
                        begin
                            state_next = ST_UPDATE;
                        end
                        else
                        begin
                            ram_rd_en  = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = scan_idx_reg;
                    state_next   = ST_UPDATE;
                end
                else
                begin
                    if ((scan_idx_reg == '0) || (cur_stamp < min_stamp_reg))
                    begin
                        min_stamp_next = cur_stamp;
                        victim_next    = scan_idx_reg;
                    end
                    if (scan_last)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = scan_idx_reg + 1'b1;
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end
            ST_UPDATE:
            begin
                ram_wr_en = 1'b1;
                if (hit_reg)
                begin
                    ram_wr_addr = hit_idx_reg;
                end
                else if (can_insert)
                begin
                    ram_wr_addr     = slots_used_reg[IW-1:0];
                    slots_used_next = slots_used_reg + 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    if (hit_reg && (job_reg.verdict == mtgld_pkg::V_ACCEPT))
                    begin
                        out_verdict_next = mtgld_pkg::V_DROP_SEEN;
                        out_ttl_next     = '0;
                    end
                    else
                    begin
                        out_verdict_next = job_reg.verdict;
                        out_ttl_next     = job_reg.new_ttl;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            use_clock_reg  <= '0;
            slots_used_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            use_clock_reg  <= use_clock_next;
            slots_used_reg <= slots_used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg         <= job_next;
        scan_idx_reg    <= scan_idx_next;
        hit_reg         <= hit_next;
        hit_idx_reg     <= hit_idx_next;
        min_stamp_reg   <= min_stamp_next;
        victim_reg      <= victim_next;
        out_verdict_reg <= out_verdict_next;
        out_ttl_reg     <= out_ttl_next;
    end

    mtgld_ram #(
        .WIDTH (SLOTW),
        .DEPTH (SEEN_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign res.valid   = out_valid_reg;
    assign res.verdict = out_verdict_reg;
    assign res.new_ttl = out_ttl_reg;

endmodule

// ===== sv/mesh_ttl_guard_lru_dedup_top.sv =====
// Admission guard for mesh records: clamps the hop TTL, rejects zero-TTL and
// self-originated records, refreshes pooled records and filters repeats through an
// LRU seen set of SEEN_SLOTS ids with 32-bit use stamps held in one slot RAM. The
// front end classifies a record per cycle into a two-entry queue unless it is full;
// the back end takes one record at a time. A record that never reaches the seen set
// (TTL zero, own origin, or capacity zero) skips to emit. Any other record is looked
// up in the set, which is then updated: the slot RAM has one read port, so the
// lookup and the oldest-stamp search walk the filled slots one per cycle, stopping
// early on a hit. Results leave through an output register, one per record, in
// arrival order. Configuration writes are always ready and take effect next cycle.
module mesh_ttl_guard_lru_dedup_top #(
    parameter int SEEN_SLOTS = mtgld_pkg::SEEN_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mtgld_rec_if.sink   rec,
    mtgld_res_if.source res,
    mtgld_cfg_if.sink   cfg
);

    mtgld_pkg::cfg_t cfg_cur;
    logic            fq_valid;
    mtgld_pkg::job_t fq_job;
    logic            fq_ready;
    logic            qb_valid;
    mtgld_pkg::job_t qb_job;
    logic            qb_ready;

    mtgld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (rec),
        .cfg       (cfg),
        .cfg_out   (cfg_cur),
        .job_valid (fq_valid),
        .job       (fq_job),
        .job_ready (fq_ready)
    );

    mtgld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_job    (fq_job),
        .in_ready  (fq_ready),
        .out_valid (qb_valid),
        .out_job   (qb_job),
        .out_ready (qb_ready)
    );

    mtgld_back #(
        .SEEN_SLOTS (SEEN_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_cur),
        .job_valid (qb_valid),
        .job       (qb_job),
        .job_ready (qb_ready),
        .res       (res)
    );

endmodule

// ===== sv/mtgld_checker.sv =====
// Port-level checker for the mesh TTL guard, bound to the top level.
// Depends on mtgld_pkg and mesh_ttl_guard_lru_dedup_top_macros.svh.
`include "mesh_ttl_guard_lru_dedup_top_macros.svh"

module mtgld_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [mtgld_pkg::VERDICT_W-1:0] res_verdict,
    input logic [mtgld_pkg::TTL_W-1:0]     res_new_ttl
);

    `MTGLD_ASSERT_NEXT(a_res_hold,
        res_valid && !res_ready,
        res_valid,
        "result beat dropped while stalled")
    `MTGLD_ASSERT_IMPL(a_verdict_code,
        res_valid,
        res_verdict <= mtgld_pkg::V_DROP_SEEN,
        "unknown verdict code")
    `MTGLD_ASSERT_IMPL(a_drop_ttl_zero,
        res_valid && (res_verdict == mtgld_pkg::V_DROP_TTL
                      || res_verdict == mtgld_pkg::V_DROP_OWN
                      || res_verdict == mtgld_pkg::V_DROP_SEEN),
        res_new_ttl == '0,
        "drop verdict with nonzero TTL")
    `MTGLD_ASSERT_IMPL(a_accept_ttl,
        res_valid && res_verdict == mtgld_pkg::V_ACCEPT,
        res_new_ttl != '1,
        "accepted TTL not decremented")

endmodule

bind mesh_ttl_guard_lru_dedup_top mtgld_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_verdict (res.verdict),
    .res_new_ttl (res.new_ttl)
);

// ===== dv/mesh_ttl_guard_lru_dedup_top_tb.sv =====
// Self-checking bench for the mesh TTL guard: directed table, then random records
// across several register settings, each verdict checked against its table entry or an LRU predictor.
// Depends on mtgld_pkg, the channel interfaces and mesh_ttl_guard_lru_dedup_top.
`timescale 1ns / 1ps

module mesh_ttl_guard_lru_dedup_top_tb;

    import mtgld_pkg::*;

    localparam int SLOTS       = SEEN_SLOTS_DEF;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 270;
    localparam int RANDOM_ITEMS = PHASES * PHASE_ITEMS;
    localparam int TAIL_CYCLES = 40;

    typedef enum logic { ROW_REC, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic [ID_W-1:0]   record_id;
        logic [TTL_W-1:0]  wire_ttl;
        logic [NODE_W-1:0] origin_id;
        logic              in_pool;
        logic [TTL_W-1:0]  pool_hops;
    } rec_beat_t;

    typedef struct packed {
        verdict_t         verdict;
        logic [TTL_W-1:0] new_ttl;
    } guard_result_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
        rec_beat_t             rec;
        logic                  typed;
        guard_result_t         want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mtgld_rec_if rec_if ();
    mtgld_res_if res_if ();
    mtgld_cfg_if cfg_if ();

    mesh_ttl_guard_lru_dedup_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rec   (rec_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    logic [NODE_W-1:0]  node_id;
    logic [TTL_W-1:0]   hop_ceiling;
    logic [CAP_W-1:0]   seen_cap;
    logic [ID_W-1:0]    seen_ids [SLOTS];
    logic [STAMP_W-1:0] seen_stamps [SLOTS];
    int unsigned        seen_fill;
    logic [STAMP_W-1:0] stamp_clock;

    guard_result_t pending_verdicts [$];
    stim_row_t     directed_rows [$];
    int            mismatches;
    int            send_idle;
    int            recv_idle;
    logic [ID_W-1:0] id_base;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // LRU seen set: returns 1 on a hit, inserts or evicts on a miss, does nothing at capacity zero
    function automatic logic touch_seen(input logic [ID_W-1:0] id);
        int unsigned cap;
        int unsigned victim;
        logic [STAMP_W-1:0] oldest;
        cap = (seen_cap > SLOTS) ? SLOTS : seen_cap;
        if (cap == 0)
        begin
            return 1'b0;
        end
        stamp_clock = stamp_clock + 1'b1;
        for (int i = 0; i < seen_fill; i++)
        begin
            if (seen_ids[i] == id)
            begin
                seen_stamps[i] = stamp_clock;
                return 1'b1;
            end
        end
        if (seen_fill < cap)
        begin
            seen_ids[seen_fill]    = id;
            seen_stamps[seen_fill] = stamp_clock;
            seen_fill++;
        end
        else
        begin
            victim = 0;
            oldest = seen_stamps[0];
            for (int i = 1; i < seen_fill; i++)
            begin
                if (seen_stamps[i] < oldest)
                begin
                    oldest = seen_stamps[i];
                    victim = i;
                end
            end
            seen_ids[victim]    = id;
            seen_stamps[victim] = stamp_clock;
        end
        return 1'b0;
    endfunction

    function automatic guard_result_t judge_record(input rec_beat_t r);
        guard_result_t o;
        logic [TTL_W-1:0] ttl;
        o.new_ttl = '0;
        ttl = (r.wire_ttl > hop_ceiling) ? hop_ceiling : r.wire_ttl;
        if (ttl == 0)
        begin
            o.verdict = V_DROP_TTL;
        end
        else if (r.origin_id != 0 && r.origin_id == node_id)
        begin
            o.verdict = V_DROP_OWN;
        end
        else if (r.in_pool)
        begin
            o.new_ttl = (ttl < r.pool_hops) ? ttl : r.pool_hops;
            void'(touch_seen(r.record_id));
            o.verdict = V_REFRESH;
        end
        else if (touch_seen(r.record_id))
        begin
            o.verdict = V_DROP_SEEN;
        end
        else
        begin
            o.new_ttl = ttl - 1'b1;
            o.verdict = V_ACCEPT;
        end
        return o;
    endfunction

    function automatic stim_row_t rec_row(input logic [ID_W-1:0] id,
                                          input logic [TTL_W-1:0] ttl,
                                          input logic [NODE_W-1:0] origin,
                                          input logic pooled,
                                          input logic [TTL_W-1:0] hops,
                                          input logic typed,
                                          input verdict_t v,
                                          input logic [TTL_W-1:0] t);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_REC;
        row.rec       = '{id, ttl, origin, pooled, hops};
        row.typed     = typed;
        row.want      = '{v, t};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] wdata);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.cfg_index = idx;
        row.cfg_data  = wdata;
        return row;
    endfunction

    function automatic rec_beat_t make_record();
        rec_beat_t r;
        r.record_id = ($urandom_range(9) == 0) ? ID_W'($urandom)
                                               : id_base + ID_W'($urandom_range(23));
        case ($urandom_range(9))
            0:       r.wire_ttl = '0;
            1:       r.wire_ttl = '1;
            2, 3, 4: r.wire_ttl = TTL_W'($urandom);
            default: r.wire_ttl = TTL_W'($urandom_range(20, 1));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4: r.origin_id = '0;
            5:             r.origin_id = node_id;
            default:       r.origin_id = $urandom;
        endcase
        r.in_pool   = ($urandom_range(3) == 0);
        r.pool_hops = TTL_W'($urandom);
        return r;
    endfunction

    task automatic send_record(input rec_beat_t r, input logic typed,
                               input guard_result_t want);
        guard_result_t predicted;
        while ($urandom_range(99) < send_idle)
        begin
            rec_if.valid <= 1'b0;
            @(negedge clk);
        end
        rec_if.valid     <= 1'b1;
        rec_if.record_id <= r.record_id;
        rec_if.wire_ttl  <= r.wire_ttl;
        rec_if.origin_id <= r.origin_id;
        rec_if.in_pool   <= r.in_pool;
        rec_if.pool_hops <= r.pool_hops;
        do
            @(posedge clk);
        while (!rec_if.ready);
        predicted = judge_record(r);
        pending_verdicts.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // hold the record channel until every outstanding verdict has come back
    task automatic wait_drained();
        rec_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] wdata);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= wdata;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            CFG_OWN_NODE:    node_id     = wdata;
            CFG_TTL_CEILING: hop_ceiling = wdata[TTL_W-1:0];
            CFG_SEEN_CAP:    seen_cap    = wdata[CAP_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        guard_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("verdict %0d ttl %0d with nothing pending",
                                          res_if.verdict, res_if.new_ttl));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (res_if.verdict !== want.verdict)
                begin
                    report_mismatch($sformatf("verdict %0d, want %0d",
                                              res_if.verdict, want.verdict));
                end
                if (res_if.new_ttl !== want.new_ttl)
                begin
                    report_mismatch($sformatf("new_ttl %0d, want %0d",
                                              res_if.new_ttl, want.new_ttl));
                end
            end
        end
    end

    initial
    begin
        stim_row_t         row;
        int                sent;
        logic [NODE_W-1:0] own;
        logic [TTL_W-1:0]  ceil;
        logic [CAP_W-1:0]  cap;

        rst_n            = 1'b0;
        rec_if.valid     = 1'b0;
        rec_if.record_id = '0;
        rec_if.wire_ttl  = '0;
        rec_if.origin_id = '0;
        rec_if.in_pool   = 1'b0;
        rec_if.pool_hops = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        res_if.ready     = 1'b0;

        node_id     = OWN_NODE_RST;
        hop_ceiling = TTL_CEILING_RST;
        seen_cap    = SEEN_CAP_RST;
        seen_fill   = 0;
        stamp_clock = '0;
        mismatches  = 0;
        send_idle   = 15;
        recv_idle   = 65;
        sent        = 0;

        directed_rows.push_back(rec_row(16'h0000, 8'd0, 32'h0, 1'b0, 8'd0,
                                        1'b1, V_DROP_TTL, 8'd0));
        directed_rows.push_back(rec_row(16'hFFFF, 8'd255, 32'h0, 1'b0, 8'd255,
                                        1'b1, V_ACCEPT, 8'd6));
        directed_rows.push_back(rec_row(16'hFFFF, 8'd3, 32'h0, 1'b0, 8'd0,
                                        1'b1, V_DROP_SEEN, 8'd0));
        directed_rows.push_back(rec_row(16'h1234, 8'd1, 32'hFFFF_FFFF, 1'b1, 8'd0,
                                        1'b1, V_REFRESH, 8'd0));
        directed_rows.push_back(rec_row(16'h1234, 8'd5, 32'h1, 1'b0, 8'd0,
                                        1'b1, V_DROP_SEEN, 8'd0));
        directed_rows.push_back(rec_row(16'h0002, 8'd200, 32'h0, 1'b1, 8'd255,
                                        1'b1, V_REFRESH, 8'd7));
        directed_rows.push_back(rec_row(16'h0003, 8'd1, 32'h0, 1'b0, 8'd0,
                                        1'b1, V_ACCEPT, 8'd0));
        directed_rows.push_back(cfg_row(CFG_OWN_NODE, 32'hFFFF_FFFF));
        directed_rows.push_back(cfg_row(CFG_TTL_CEILING, 32'd255));
        directed_rows.push_back(rec_row(16'h000A, 8'd255, 32'hFFFF_FFFF, 1'b0, 8'd0,
                                        1'b1, V_DROP_OWN, 8'd0));
        directed_rows.push_back(rec_row(16'h000B, 8'd255, 32'h0, 1'b0, 8'd0,
                                        1'b1, V_ACCEPT, 8'd254));
        directed_rows.push_back(rec_row(16'h000C, 8'd0, 32'hFFFF_FFFF, 1'b0, 8'd0,
                                        1'b1, V_DROP_TTL, 8'd0));
        directed_rows.push_back(rec_row(16'h000B, 8'd255, 32'hFFFF_FFFE, 1'b1, 8'd100,
                                        1'b1, V_REFRESH, 8'd100));
        directed_rows.push_back(cfg_row(CFG_SEEN_CAP, 32'd0));
        directed_rows.push_back(rec_row(16'h000B, 8'd9, 32'h0, 1'b0, 8'd0,
                                        1'b1, V_ACCEPT, 8'd8));
        directed_rows.push_back(rec_row(16'h000B, 8'd9, 32'h0, 1'b0, 8'd0,
                                        1'b1, V_ACCEPT, 8'd8));
        directed_rows.push_back(cfg_row(CFG_OWN_NODE, 32'h0));
        directed_rows.push_back(cfg_row(CFG_TTL_CEILING, 32'd0));
        directed_rows.push_back(rec_row(16'h55AA, 8'd255, 32'h0, 1'b1, 8'd255,
                                        1'b1, V_DROP_TTL, 8'd0));
        directed_rows.push_back(cfg_row(CFG_TTL_CEILING, 32'd100));
        directed_rows.push_back(cfg_row(CFG_SEEN_CAP, 32'd2));
        directed_rows.push_back(rec_row(16'h0028, 8'd50, 32'h0, 1'b0, 8'd0,
                                        1'b0, V_ACCEPT, 8'd0));
        directed_rows.push_back(rec_row(16'hFFFF, 8'd50, 32'h0, 1'b0, 8'd0,
                                        1'b0, V_ACCEPT, 8'd0));
        directed_rows.push_back(rec_row(16'h1234, 8'd50, 32'h0, 1'b1, 8'd20,
                                        1'b0, V_ACCEPT, 8'd0));
        directed_rows.push_back(rec_row(16'h0028, 8'd50, 32'h0, 1'b0, 8'd0,
                                        1'b0, V_ACCEPT, 8'd0));
        directed_rows.push_back(cfg_row(CFG_SEEN_CAP, 32'd31));
        directed_rows.push_back(rec_row(16'h0100, 8'd12, 32'h5, 1'b0, 8'd0,
                                        1'b0, V_ACCEPT, 8'd0));
        directed_rows.push_back(rec_row(16'h0101, 8'd12, 32'h5, 1'b0, 8'd0,
                                        1'b0, V_ACCEPT, 8'd0));
        directed_rows.push_back(rec_row(16'h0100, 8'd12, 32'h5, 1'b0, 8'd0,
                                        1'b0, V_ACCEPT, 8'd0));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                if (i == 0 || directed_rows[i-1].kind != ROW_CFG)
                begin
                    wait_drained();
                end
                write_reg(row.cfg_index, row.cfg_data);
                if (i + 1 == directed_rows.size() || directed_rows[i+1].kind != ROW_CFG)
                begin
                    cfg_if.valid <= 1'b0;
                end
            end
            else
            begin
                send_record(row.rec, row.typed, row.want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin own = '0;            ceil = 8'd7;   cap = 5'd16; end
                1:       begin own = $urandom;      ceil = 8'd255; cap = 5'd16; end
                2:       begin own = $urandom;      ceil = 8'd15;  cap = 5'd4;  end
                3:       begin own = 32'hFFFF_FFFF; ceil = 8'd63;  cap = 5'd1;  end
                4:       begin own = $urandom;      ceil = 8'd200; cap = 5'd0;  end
                5:       begin own = $urandom;      ceil = 8'd31;  cap = 5'd31; end
                default: begin own = $urandom;      ceil = 8'd8;   cap = 5'd8;  end
            endcase
            wait_drained();
            write_reg(CFG_OWN_NODE, own);
            write_reg(CFG_TTL_CEILING, CFG_DATA_W'(ceil));
            write_reg(CFG_SEEN_CAP, CFG_DATA_W'(cap));
            cfg_if.valid <= 1'b0;
            id_base = ID_W'($urandom);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case (sent * 3 / RANDOM_ITEMS)
                    0:       begin send_idle = 15; recv_idle = 65; end
                    1:       begin send_idle = 65; recv_idle = 15; end
                    default: begin send_idle = 0;  recv_idle = 0;  end
                endcase
                if (sent % 97 == 96)
                begin
                    wait_drained();
                end
                send_record(make_record(), 1'b0, '0);
                sent++;
            end
        end

        rec_if.valid <= 1'b0;
        for (int w = 0; w < 200000 && pending_verdicts.size() != 0; w++)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_verdicts.size() != 0)
        begin
            report_mismatch($sformatf("%0d verdicts never arrived",
                                      pending_verdicts.size()));
        end
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== mesh_ttl_guard_lru_dedup_top.f =====
+incdir+sv
sv/mtgld_pkg.sv
sv/mtgld_ifs.sv
sv/mtgld_ram.sv
sv/mtgld_front.sv
sv/mtgld_queue.sv
sv/mtgld_back.sv
sv/mesh_ttl_guard_lru_dedup_top.sv
sv/mtgld_checker.sv
dv/mesh_ttl_guard_lru_dedup_top_tb.sv
